>>> sv/vtp_pkg.sv
package vtp_pkg;

    localparam int NUM_REGS = 8;
    localparam int REG_W    = 64;

    // Stages of the divider: operand setup, range check, 33 quotient bits, final rounding.
    localparam int DIV_Q    = 33;
    localparam int DIV_LAT  = DIV_Q + 3;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        REG_X_A = 3'd0,
        REG_X_B = 3'd1,
        REG_Y_A = 3'd2,
        REG_Y_B = 3'd3,
        REG_Z_A = 3'd4,
        REG_Z_B = 3'd5,
        REG_W_A = 3'd6,
        REG_W_B = 3'd7
    } reg_idx_t;

    typedef logic [NUM_REGS-1:0][REG_W-1:0] coef_arr_t;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic signed [31:0] cw;
    } clip_t;

endpackage

>>> sv/vertex_transform_project_clip.sv
// Vertex transform, clip test, perspective divide and viewport map.
// Input words on s_axis carry one object-space vertex (x, y, z in Q16.16);
// each input word gives exactly one output word on m_axis with screen x/y,
// depth z/w, clip w and the hidden and zero-w flags.
// The 4x4 matrix is loaded through cfg_we/cfg_addr/cfg_wdata, two Q16.16
// coefficients per 64-bit register; load it only while the pipeline is empty.
// From input to output the pipeline has three stages of matrix multiply
// and rounding, two stages of clip test and numerator scaling, and a 36-stage
// divider (operand setup, range check, 33 stages of one quotient bit each and
// a final rounding stage). Throughput is one vertex per cycle while m_axis
// is not stalled, set by the fully pipelined multipliers and divider.
// Reset empties the pipeline and loads the identity matrix.
// When the receiver holds m_axis_tready low with a word waiting, the whole
// pipeline freezes and s_axis_tready drops in the same cycle; nothing is
// dropped or repeated, and flow resumes as soon as the word is taken.
module vertex_transform_project_clip #(
    parameter int SCREEN_W = 800,
    parameter int SCREEN_H = 600
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [95:0]   s_axis_tdata,   // vert_x, vert_y, vert_z
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // screen_x, screen_y, depth_z, clip_w
    output logic [1:0]    m_axis_tuser,   // hidden, w_zero
    input  logic          cfg_we,
    input  logic [2:0]    cfg_addr,
    input  logic [63:0]   cfg_wdata
);
    import vtp_pkg::*;

    localparam int TOT = 5 + DIV_LAT;
    localparam logic signed [15:0] SW_C = 16'(SCREEN_W);
    localparam logic signed [15:0] SH_C = 16'(SCREEN_H);

    coef_arr_t          coef_reg;
    logic               en;
    logic [TOT-1:0]     vld_reg;
    clip_t              clip;

    logic signed [32:0] sx_reg, sy_reg;
    logic signed [31:0] cz_reg, cw4_reg;
    logic               hid4_reg, wz4_reg;
    logic               hid_next;

    logic signed [63:0] nx_reg, ny_reg, nz_reg;
    logic signed [34:0] d2_reg, d1_reg;
    logic               wz5_reg;
    logic signed [48:0] mx, my;

    logic signed [31:0] cw_pipe_reg  [DIV_LAT+1];
    logic               hid_pipe_reg [DIV_LAT+1];
    logic               wz_pipe_reg  [DIV_LAT+1];

    logic signed [31:0] scr_x, scr_y, dep_z;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[TOT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[REG_X_A] <= 64'h0000_0000_0001_0000;
            coef_reg[REG_X_B] <= 64'h0;
            coef_reg[REG_Y_A] <= 64'h0001_0000_0000_0000;
            coef_reg[REG_Y_B] <= 64'h0;
            coef_reg[REG_Z_A] <= 64'h0;
            coef_reg[REG_Z_B] <= 64'h0000_0000_0001_0000;
            coef_reg[REG_W_A] <= 64'h0;
            coef_reg[REG_W_B] <= 64'h0001_0000_0000_0000;
        end
        else if (cfg_we)
        begin
            coef_reg[cfg_addr] <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[TOT-2:0], s_axis_tvalid};
    end

    vtp_transform u_xf (
        .clk  (clk),
        .en   (en),
        .vx   ($signed(s_axis_tdata[31:0])),
        .vy   ($signed(s_axis_tdata[63:32])),
        .vz   ($signed(s_axis_tdata[95:64])),
        .coef (coef_reg),
        .clip (clip)
    );

    always_comb
    begin
        hid_next = (clip.cw == 32'sd0)
                || (33'(clip.cx) < -33'(clip.cw)) || (clip.cx > clip.cw)
                || (33'(clip.cy) < -33'(clip.cw)) || (clip.cy > clip.cw)
                || (clip.cz < 32'sd0) || (clip.cz > clip.cw);
    end

    assign mx = 49'(sx_reg) * 49'(SW_C);
    assign my = 49'(sy_reg) * 49'(SH_C);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg   <= 33'(clip.cx) + 33'(clip.cw);
            sy_reg   <= 33'(clip.cw) - 33'(clip.cy);
            cz_reg   <= clip.cz;
            cw4_reg  <= clip.cw;
            hid4_reg <= hid_next;
            wz4_reg  <= (clip.cw == 32'sd0);

            nx_reg   <= {mx[47:0], 16'h0000};
            ny_reg   <= {my[47:0], 16'h0000};
            nz_reg   <= {{16{cz_reg[31]}}, cz_reg, 16'h0000};
            d2_reg   <= {{2{cw4_reg[31]}}, cw4_reg, 1'b0};
            d1_reg   <= 35'(cw4_reg);
            wz5_reg  <= wz4_reg;

            cw_pipe_reg[0]  <= wz4_reg ? 32'sd0 : cw4_reg;
            hid_pipe_reg[0] <= hid4_reg;
            wz_pipe_reg[0]  <= wz4_reg;
            for (int i = 0; i < DIV_LAT; i++)
            begin
                cw_pipe_reg[i+1]  <= cw_pipe_reg[i];
                hid_pipe_reg[i+1] <= hid_pipe_reg[i];
                wz_pipe_reg[i+1]  <= wz_pipe_reg[i];
            end
        end
    end

    vtp_divider u_div_x (.clk(clk), .en(en), .n(nx_reg), .d(d2_reg), .wz(wz5_reg), .q(scr_x));
    vtp_divider u_div_y (.clk(clk), .en(en), .n(ny_reg), .d(d2_reg), .wz(wz5_reg), .q(scr_y));
    vtp_divider u_div_z (.clk(clk), .en(en), .n(nz_reg), .d(d1_reg), .wz(wz5_reg), .q(dep_z));

    assign m_axis_tdata = {cw_pipe_reg[DIV_LAT], dep_z, scr_y, scr_x};
    assign m_axis_tuser = {wz_pipe_reg[DIV_LAT], hid_pipe_reg[DIV_LAT]};

    a_wz_hidden: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("zero w without hidden flag");

    a_wz_clipw: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[127:96] == 32'h0)
        else $error("zero w with nonzero clip w");

    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            !m_axis_tdata[95] && $signed(m_axis_tdata[95:64]) <= 32'sd65536)
        else $error("visible vertex with depth outside zero to one");

endmodule

>>> sv/vtp_transform.sv
module vtp_transform (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] vx,
    input  logic signed [31:0] vy,
    input  logic signed [31:0] vz,
    input  vtp_pkg::coef_arr_t coef,
    output vtp_pkg::clip_t     clip
);
    import vtp_pkg::*;

    logic signed [63:0] prod_next [4][4];
    logic signed [63:0] prod_reg  [4][4];
    logic signed [65:0] sum_next  [4];
    logic signed [65:0] sum_reg   [4];
    logic signed [31:0] col_next  [4];
    logic signed [31:0] col_reg   [4];

    // Column c takes its four coefficients from registers 2c and 2c+1.
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            prod_next[c][0] = vx * $signed(coef[2*c][31:0]);
            prod_next[c][1] = vy * $signed(coef[2*c][63:32]);
            prod_next[c][2] = vz * $signed(coef[2*c+1][31:0]);
            prod_next[c][3] = {{16{coef[2*c+1][63]}}, coef[2*c+1][63:32], 16'h0000};
        end
    end

    // Exact Q34.32 sum plus one half, so that the shift below rounds halves upward.
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            sum_next[c] = 66'(prod_reg[c][0]) + 66'(prod_reg[c][1]) + 66'(prod_reg[c][2])
                        + 66'(prod_reg[c][3]) + 66'sd32768;
        end
    end

    always_comb
    begin
        logic signed [65:0] t;
        for (int c = 0; c < 4; c++)
        begin
            t = sum_reg[c] >>> 16;
            if (t > 66'sd2147483647)
                col_next[c] = Q_MAX;
            else if (t < -66'sd2147483648)
                col_next[c] = Q_MIN;
            else
                col_next[c] = t[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
            col_reg  <= col_next;
        end
    end

    assign clip.cx = col_reg[0];
    assign clip.cy = col_reg[1];
    assign clip.cz = col_reg[2];
    assign clip.cw = col_reg[3];

endmodule

>>> sv/vtp_divider.sv
module vtp_divider (
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] n,
    input  logic signed [34:0] d,
    input  logic               wz,
    output logic signed [31:0] q
);
    import vtp_pkg::*;

    typedef struct packed {
        logic neg;
        logic wz;
        logic n_neg;
        logic n_nz;
        logic ovf;
    } div_flags_t;

    logic [63:0]      un_next;
    logic [33:0]      ud_next;
    div_flags_t       fl_next;
    logic [63:0]      un_reg;
    logic [33:0]      ud_reg;
    div_flags_t       fl_reg;

    logic [63:0]      rem_reg [DIV_Q+1];
    logic [DIV_Q-1:0] quo_reg [DIV_Q+1];
    logic [33:0]      dsr_reg [DIV_Q+1];
    div_flags_t       flp_reg [DIV_Q+1];

    logic signed [31:0] q_next;
    logic signed [31:0] q_reg;

    // Magnitudes, with half the divisor added so the truncating quotient rounds to nearest.
    always_comb
    begin
        logic [63:0] an;
        logic [34:0] ad;
        an = n[63] ? 64'(-n) : 64'(n);
        ad = d[34] ? 35'(-d) : 35'(d);
        ud_next       = ad[33:0];
        un_next       = an + 64'(ad[33:1]);
        fl_next.neg   = n[63] ^ d[34];
        fl_next.wz    = wz;
        fl_next.n_neg = n[63];
        fl_next.n_nz  = (n != 64'sd0);
        fl_next.ovf   = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            un_reg <= un_next;
            ud_reg <= ud_next;
            fl_reg <= fl_next;
            rem_reg[0] <= un_reg;
            quo_reg[0] <= '0;
            dsr_reg[0] <= ud_reg;
            flp_reg[0] <= '{neg: fl_reg.neg, wz: fl_reg.wz, n_neg: fl_reg.n_neg,
                            n_nz: fl_reg.n_nz,
                            ovf: ({3'b000, un_reg} >= {ud_reg, 33'h0})};
        end
    end

    // One restoring step per stage, most significant quotient bit first.
    for (genvar j = 0; j < DIV_Q; j++)
    begin : g_step
        localparam int K = DIV_Q - 1 - j;
        logic [66:0] shd;
        logic        ge;
        assign shd = {33'h0, dsr_reg[j]} << K;
        assign ge  = ({3'b000, rem_reg[j]} >= shd);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= ge ? 64'({3'b000, rem_reg[j]} - shd) : rem_reg[j];
                quo_reg[j+1] <= quo_reg[j] | (DIV_Q'(ge) << K);
                dsr_reg[j+1] <= dsr_reg[j];
                flp_reg[j+1] <= flp_reg[j];
            end
        end
    end

    always_comb
    begin
        div_flags_t       f;
        logic [DIV_Q-1:0] qq;
        f  = flp_reg[DIV_Q];
        qq = quo_reg[DIV_Q];
        if (f.wz)
            q_next = f.n_nz ? (f.n_neg ? Q_MIN : Q_MAX) : 32'sd0;
        else if (f.neg)
            q_next = (f.ovf || qq > DIV_Q'(33'h0_8000_0000)) ? Q_MIN : 32'(-qq);
        else
            q_next = (f.ovf || qq > DIV_Q'(33'h0_7FFF_FFFF)) ? Q_MAX : qq[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule
